// ===== hw/rtl/pdm_pkg.sv =====
// Shared types, constants and helper functions of the projected descriptor matcher.
package pdm_pkg;

    // Fixed field widths of the request and result channels
    localparam int IDX_W         = 10;
    localparam int COORD_W       = 32;
    localparam int CFG_W         = 31;
    localparam int CFG_IDX_W     = 3;
    localparam int DIM_W         = 13;
    localparam int COUNT_W       = 11;
    localparam int DESC_BITS     = 256;
    localparam int DESC_WORD_W   = 64;
    localparam int DESC_WORDS    = DESC_BITS / DESC_WORD_W;
    localparam int S_TDATA_W     = 368;
    localparam int S_TUSER_W     = 2;
    localparam int M_TDATA_W     = 56;
    localparam int M_TUSER_W     = 1;

    // Default keypoint capacity and the number of slots the index field can reach
    localparam int MAX_KEYPOINTS_DEF = 1024;
    localparam int SLOT_LIMIT        = 1 << IDX_W;

    // Matching constants
    localparam int HAM_W         = 9;
    localparam int DIST_INIT     = 101;
    localparam int HAMMING_LIMIT = 100;
    localparam int RECIP_TEN     = 205;
    localparam int RECIP_SHIFT   = 11;
    localparam int R2_NARROW     = 1225;
    localparam int R2_WIDE       = 4900;
    localparam int SQ_W          = 48;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_LOAD_KP   = 2'd0,
        REQ_LOAD_POSE = 2'd1,
        REQ_QUERY     = 2'd2,
        REQ_CLEAR     = 2'd3
    } req_type_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_W     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_H     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_BF = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_MODE = 3'd7;

    // Control flags that travel with each keypoint down the scan chain
    typedef struct packed {
        logic valid;
        logic en;
        logic last;
    } scan_ctl_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_CAM,
        ST_MUL_U,
        ST_DIVS_U,
        ST_DIVW_U,
        ST_MUL_V,
        ST_DIVS_V,
        ST_DIVW_V,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_FETCH,
        ST_READ,
        ST_DIVW_R,
        ST_RESULT
    } pdm_state_t;

    // Population count of one descriptor word, byte by byte
    function automatic logic [6:0] popcount64(input logic [63:0] w);
        logic [3:0] byte_cnt [8];
        logic [6:0] total;
        total = '0;
        for (int b = 0; b < 8; b++) begin
            byte_cnt[b] = '0;
            for (int k = 0; k < 8; k++) begin
                byte_cnt[b] = byte_cnt[b] + 4'(w[8*b+k]);
            end
        end
        for (int b = 0; b < 8; b++) begin
            total = total + 7'(byte_cnt[b]);
        end
        return total;
    endfunction

    // Saturate a 64-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/pdm_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
module pdm_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    import pdm_pkg::*;

    logic        run_reg,  run_next;
    logic        done_reg, done_next;
    logic [6:0]  cnt_reg,  cnt_next;
    logic [63:0] dvd_reg,  dvd_next;
    logic [32:0] rem_reg,  rem_next;
    logic [31:0] dsr_reg;
    logic [32:0] trial;

    // One shift-and-subtract step
    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg[31:0], dvd_reg[63]};
        if (start) begin
            run_next = 1'b1;
            cnt_next = 7'd64;
            dvd_next = dividend;
            rem_next = '0;
        end else if (run_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = trial - {1'b0, dsr_reg};
                dvd_next = {dvd_reg[62:0], 1'b1};
            end else begin
                rem_next = trial;
                dvd_next = {dvd_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operands carry no reset
    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (start) begin
            dsr_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ===== hw/rtl/pdm_cell.sv =====
// One scan cell: holds one descriptor word per slot and adds its Hamming share.
module pdm_cell #(
    parameter int KP_DEPTH = pdm_pkg::MAX_KEYPOINTS_DEF,
    parameter int AW       = $clog2(KP_DEPTH)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [pdm_pkg::DESC_WORD_W-1:0] wr_data,
    input  logic [pdm_pkg::DESC_WORD_W-1:0] qword,
    input  pdm_pkg::scan_ctl_t           in_ctl,
    input  logic [AW-1:0]                in_slot,
    input  logic [pdm_pkg::HAM_W-1:0]    in_sum,
    output pdm_pkg::scan_ctl_t           out_ctl,
    output logic [AW-1:0]                out_slot,
    output logic [pdm_pkg::HAM_W-1:0]    out_sum
);
    import pdm_pkg::*;

    logic [DESC_WORD_W-1:0] mem [KP_DEPTH];
    logic [DESC_WORD_W-1:0] rd_q;
    scan_ctl_t              mid_ctl_reg, out_ctl_reg;
    logic [AW-1:0]          mid_slot_reg, out_slot_reg;
    logic [HAM_W-1:0]       mid_sum_reg, out_sum_reg;

    // Descriptor word store: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[in_slot];
    end

    // Control flags of both stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_ctl_reg <= '0;
            out_ctl_reg <= '0;
        end else begin
            mid_ctl_reg <= in_ctl;
            out_ctl_reg <= mid_ctl_reg;
        end
    end

    // Partial distance handed on to the next cell
    always_ff @(posedge aclk) begin
        mid_slot_reg <= in_slot;
        mid_sum_reg  <= in_sum;
        out_slot_reg <= mid_slot_reg;
        out_sum_reg  <= mid_sum_reg + HAM_W'(popcount64(rd_q ^ qword));
    end

    assign out_ctl  = out_ctl_reg;
    assign out_slot = out_slot_reg;
    assign out_sum  = out_sum_reg;

endmodule

// ===== hw/rtl/projected_descriptor_matcher_unit.sv =====
// Top level of the projected descriptor matcher: sequencer, geometry and scan chain.
//
// Requests arrive on the s_ stream; s_tuser carries the request kind and s_tdata
// the slot or pose index, three Q16.16 coordinates and the 256-bit descriptor.
// Keypoint loads, pose loads and clears give no result; each query gives one
// result on the m_ stream: m_tuser is the found flag, m_tdata the slot, the
// right-image u and the running match count. Registers are written through
// the cfg_ port; the user must write them only while the block is idle, as
// the block itself does not enforce it. A clear sweeps the used flags of all
// slots to zero. A query runs the pose multiply row by row, up to three runs
// of the shared bit-serial divider (u, v and right u) and a pass of the
// stored keypoints through the geometry pipeline and the scan chain.
// One request is worked on at a time; the next request is taken while a
// finished result still waits in the output register.
// After reset the used flags are swept to zero before the first request is
// taken. If the receiver stalls, the result is held and a later query waits
// before its result is written.
module projected_descriptor_matcher_unit #(
    parameter int MAX_KEYPOINTS = pdm_pkg::MAX_KEYPOINTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // item_index, coord_x, coord_y, coord_z, desc_w0, desc_w1, desc_w2, desc_w3
    input  logic [pdm_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type
    input  logic [pdm_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // match_slot, u_right, match_count
    output logic [pdm_pkg::M_TDATA_W-1:0]   m_tdata,
    // found
    output logic [pdm_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                            cfg_wr_en,
    input  logic [pdm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pdm_pkg::CFG_W-1:0]       cfg_wdata
);
    import pdm_pkg::*;

    localparam int KP_DEPTH = (MAX_KEYPOINTS > SLOT_LIMIT) ? SLOT_LIMIT : MAX_KEYPOINTS;
    localparam int AW       = $clog2(KP_DEPTH);
    localparam int NCELL    = DESC_WORDS;

    // Request fields
    logic [IDX_W-1:0]       s_idx;
    logic signed [31:0]     s_x, s_y, s_z;
    logic [DESC_WORD_W-1:0] s_w [DESC_WORDS];
    logic                   accept;
    logic                   idx_ok;

    assign s_idx = s_tdata[9:0];
    assign s_x   = s_tdata[41:10];
    assign s_y   = s_tdata[73:42];
    assign s_z   = s_tdata[105:74];
    always_comb begin
        for (int i = 0; i < DESC_WORDS; i++) begin
            s_w[i] = s_tdata[106 + DESC_WORD_W*i +: DESC_WORD_W];
        end
    end
    assign accept = s_tvalid && s_tready;
    assign idx_ok = ({22'd0, s_idx} < 32'(KP_DEPTH));

    // Configuration registers
    logic [CFG_W-1:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg, stereo_bf_reg;
    logic [DIM_W-1:0] img_w_reg, img_h_reg;
    logic             lost_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg   <= '0;
            focal_y_reg   <= '0;
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            stereo_bf_reg <= '0;
            img_w_reg     <= DIM_W'(640);
            img_h_reg     <= DIM_W'(480);
            lost_reg      <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FOCAL_X:   focal_x_reg   <= cfg_wdata;
                CFG_FOCAL_Y:   focal_y_reg   <= cfg_wdata;
                CFG_CENTER_X:  center_x_reg  <= cfg_wdata;
                CFG_CENTER_Y:  center_y_reg  <= cfg_wdata;
                CFG_IMG_W:     img_w_reg     <= cfg_wdata[DIM_W-1:0];
                CFG_IMG_H:     img_h_reg     <= cfg_wdata[DIM_W-1:0];
                CFG_STEREO_BF: stereo_bf_reg <= cfg_wdata;
                CFG_LOST_MODE: lost_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Sequencer state
    pdm_state_t state_reg, state_next;

    // Pose table, identity after reset
    logic signed [31:0] pose_reg [12];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 12; i++) begin
                pose_reg[i] <= ((i == 0) || (i == 5) || (i == 10)) ? 32'sd65536 : 32'sd0;
            end
        end else if (accept && (req_type_t'(s_tuser) == REQ_LOAD_POSE) && (s_idx < 10'd12)) begin
            pose_reg[s_idx[3:0]] <= s_x;
        end
    end

    // Query payload held for the whole query
    logic signed [31:0]     q_x_reg, q_y_reg, q_z_reg;
    logic [DESC_WORD_W-1:0] qw_reg [DESC_WORDS];

    always_ff @(posedge aclk) begin
        if (accept && (req_type_t'(s_tuser) == REQ_QUERY)) begin
            q_x_reg <= s_x;
            q_y_reg <= s_y;
            q_z_reg <= s_z;
            for (int i = 0; i < DESC_WORDS; i++) begin
                qw_reg[i] <= s_w[i];
            end
        end
    end

    // Keypoint stores: position, depth and used flags
    logic [63:0]        pos_mem [KP_DEPTH];
    logic [31:0]        dep_mem [KP_DEPTH];
    logic               used_mem [KP_DEPTH];
    logic [63:0]        pos_q;
    logic [31:0]        dep_q;
    logic               used_q;
    logic [AW-1:0]      rd_addr;
    logic               used_we, used_wd;
    logic [AW-1:0]      used_wa;
    logic               kp_we;
    logic [AW-1:0]      scan_addr_reg, sweep_addr_reg, best_j_reg;
    logic [AW:0]        kp_total_reg;

    assign kp_we   = accept && (req_type_t'(s_tuser) == REQ_LOAD_KP) && idx_ok;
    assign rd_addr = (state_reg == ST_SCAN) ? scan_addr_reg : best_j_reg;

    always_ff @(posedge aclk) begin
        if (kp_we) begin
            pos_mem[s_idx[AW-1:0]] <= {s_y, s_x};
            dep_mem[s_idx[AW-1:0]] <= s_z;
        end
        if (used_we) begin
            used_mem[used_wa] <= used_wd;
        end
        pos_q  <= pos_mem[rd_addr];
        dep_q  <= dep_mem[rd_addr];
        used_q <= used_mem[rd_addr];
    end

    // Highest loaded slot plus one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_total_reg <= '0;
        end else if (kp_we && ((AW+1)'(s_idx[AW-1:0]) + 1'b1 > kp_total_reg)) begin
            kp_total_reg <= (AW+1)'(s_idx[AW-1:0]) + 1'b1;
        end
    end

    // Camera point: one multiply per cycle, accumulated row by row
    logic [1:0]          ir_reg, ic_reg, pr_reg, pc_reg;
    logic                iss_reg, pv_reg;
    logic signed [63:0]  prod_reg, acc_reg;
    logic signed [31:0]  cam_reg [3];
    logic signed [31:0]  cam_in;
    logic signed [63:0]  term;
    logic                cam_done;

    always_comb begin
        case (ic_reg)
            2'd0:    cam_in = q_x_reg;
            2'd1:    cam_in = q_y_reg;
            default: cam_in = q_z_reg;
        endcase
    end
    assign term     = prod_reg >>> 16;
    assign cam_done = pv_reg && (pr_reg == 2'd2) && (pc_reg == 2'd2);

    // Divider shared by u, v and right u
    logic        div_start, div_done;
    logic [63:0] div_dvd, div_q;
    logic [31:0] div_dsr;
    logic signed [31:0] den;
    logic signed [63:0] prod_mag;

    assign prod_mag = prod_reg[63] ? -prod_reg : prod_reg;
    assign den      = ($signed(dep_q) > 32'sd0) ? $signed(dep_q) : cam_reg[2];

    always_comb begin
        case (state_reg)
            ST_READ: begin
                div_dvd = {17'd0, stereo_bf_reg, 16'd0};
                div_dsr = den;
            end
            default: begin
                div_dvd = prod_mag;
                div_dsr = cam_reg[2];
            end
        endcase
    end

    pdm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    logic signed [63:0] u_reg, v_reg, q_signed;
    logic               out_of_image;
    assign q_signed     = prod_reg[63] ? -$signed(div_q) : $signed(div_q);
    assign out_of_image = (u_reg < 64'sd0) || (u_reg >= $signed({35'd0, img_w_reg, 16'd0}))
                       || (v_reg < 64'sd0) || (v_reg >= $signed({35'd0, img_h_reg, 16'd0}));

    // Geometry pipeline in front of the scan chain
    scan_ctl_t           ctl_g1_reg, ctl_g2_reg, ctl_g3_reg;
    logic [AW-1:0]       slot_g1_reg, slot_g2_reg, slot_g3_reg;
    logic signed [23:0]  du_g2_reg, dv_g2_reg;
    logic                ok_g2_reg, ok_g3_reg;
    logic [SQ_W-1:0]     sqx_g3_reg, sqy_g3_reg;
    logic signed [33:0]  du, dv;
    logic                near;
    logic [SQ_W:0]       r2, dist2;
    logic                scan_last;

    assign du   = 34'($signed(pos_q[31:0])) - $signed(u_reg[33:0]);
    assign dv   = 34'($signed(pos_q[63:32])) - $signed(v_reg[33:0]);
    assign near = (du < 34'sd8388608) && (du > -34'sd8388608)
               && (dv < 34'sd8388608) && (dv > -34'sd8388608);
    assign r2    = lost_reg ? ((SQ_W+1)'(R2_WIDE) << 32) : ((SQ_W+1)'(R2_NARROW) << 32);
    assign dist2 = {1'b0, sqx_g3_reg} + {1'b0, sqy_g3_reg};
    assign scan_last = ({1'b0, scan_addr_reg} == kp_total_reg - 1'b1);

    // Scan chain: one cell per descriptor word
    scan_ctl_t          chain_ctl  [NCELL+1];
    logic [AW-1:0]      chain_slot [NCELL+1];
    logic [HAM_W-1:0]   chain_sum  [NCELL+1];
    scan_ctl_t          inj_ctl_reg;
    logic [AW-1:0]      inj_slot_reg;

    assign chain_ctl[0]  = inj_ctl_reg;
    assign chain_slot[0] = inj_slot_reg;
    assign chain_sum[0]  = '0;

    for (genvar c = 0; c < NCELL; c++) begin : g_cell
        pdm_cell #(
            .KP_DEPTH (KP_DEPTH),
            .AW       (AW)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .wr_en    (kp_we),
            .wr_addr  (s_idx[AW-1:0]),
            .wr_data  (s_w[c]),
            .qword    (qw_reg[c]),
            .in_ctl   (chain_ctl[c]),
            .in_slot  (chain_slot[c]),
            .in_sum   (chain_sum[c]),
            .out_ctl  (chain_ctl[c+1]),
            .out_slot (chain_slot[c+1]),
            .out_sum  (chain_sum[c+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_g1_reg  <= '0;
            ctl_g2_reg  <= '0;
            ctl_g3_reg  <= '0;
            inj_ctl_reg <= '0;
        end else begin
            ctl_g1_reg  <= '{valid: (state_reg == ST_SCAN), en: 1'b1, last: scan_last};
            ctl_g2_reg  <= ctl_g1_reg;
            ctl_g3_reg  <= ctl_g2_reg;
            inj_ctl_reg <= '{valid: ctl_g3_reg.valid,
                             en:    ok_g3_reg && (dist2 <= r2),
                             last:  ctl_g3_reg.last};
        end
    end

    always_ff @(posedge aclk) begin
        slot_g1_reg  <= scan_addr_reg;
        slot_g2_reg  <= slot_g1_reg;
        du_g2_reg    <= du[23:0];
        dv_g2_reg    <= dv[23:0];
        ok_g2_reg    <= near && !used_q;
        slot_g3_reg  <= slot_g2_reg;
        ok_g3_reg    <= ok_g2_reg;
        sqx_g3_reg   <= SQ_W'(du_g2_reg * du_g2_reg);
        sqy_g3_reg   <= SQ_W'(dv_g2_reg * dv_g2_reg);
        inj_slot_reg <= slot_g3_reg;
    end

    // Best and second-best distance over the chain output
    logic [HAM_W-1:0]  best_reg, second_reg;
    logic              have_reg;
    logic [HAM_W-1:0]  d_out;
    logic [9:0]        seven;
    logic [17:0]       seven_scaled;
    logic [HAM_W-1:0]  tenth;
    logic              is_match;

    assign d_out        = chain_sum[NCELL];
    assign seven        = 10'(second_reg) * 10'd7;
    assign seven_scaled = 18'(seven) * 18'(RECIP_TEN);
    assign tenth        = HAM_W'(seven_scaled >> RECIP_SHIFT);
    assign is_match = have_reg && (best_reg < HAM_W'(HAMMING_LIMIT))
                   && !((second_reg < HAM_W'(HAMMING_LIMIT)) && (best_reg > tenth));

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CHECK) begin
            best_reg   <= HAM_W'(DIST_INIT);
            second_reg <= HAM_W'(DIST_INIT);
            have_reg   <= 1'b0;
            best_j_reg <= '0;
        end else if (chain_ctl[NCELL].valid && chain_ctl[NCELL].en) begin
            if (d_out < best_reg) begin
                second_reg <= best_reg;
                best_reg   <= d_out;
                best_j_reg <= chain_slot[NCELL];
                have_reg   <= 1'b1;
            end else if (d_out < second_reg) begin
                second_reg <= d_out;
            end
        end
    end

    // Match count and output register
    logic [COUNT_W-1:0] match_cnt_reg, cnt_inc;
    logic               found_reg;
    logic signed [31:0] u_right_reg;
    logic               m_valid_reg, m_valid_next;
    logic               out_load;
    logic               out_found_reg;
    logic [IDX_W-1:0]   out_slot_reg;
    logic signed [31:0] out_uright_reg;
    logic [COUNT_W-1:0] out_count_reg;

    assign cnt_inc = (match_cnt_reg == {COUNT_W{1'b1}}) ? match_cnt_reg
                                                        : match_cnt_reg + 1'b1;

    // Next state and control outputs
    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        div_start    = 1'b0;
        used_we      = 1'b0;
        used_wa      = best_j_reg;
        used_wd      = 1'b0;
        out_load     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            ST_SWEEP: begin
                used_we = 1'b1;
                used_wa = sweep_addr_reg;
                if (sweep_addr_reg == AW'(KP_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (kp_we) begin
                    used_we = 1'b1;
                    used_wa = s_idx[AW-1:0];
                end
                if (accept) begin
                    case (req_type_t'(s_tuser))
                        REQ_QUERY: state_next = ST_CAM;
                        REQ_CLEAR: state_next = ST_SWEEP;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CAM: begin
                if (cam_done) begin
                    state_next = ST_MUL_U;
                end
            end
            ST_MUL_U: begin
                state_next = (cam_reg[2] <= 32'sd0) ? ST_RESULT : ST_DIVS_U;
            end
            ST_DIVS_U: begin
                div_start  = 1'b1;
                state_next = ST_DIVW_U;
            end
            ST_DIVW_U: begin
                if (div_done) begin
                    state_next = ST_MUL_V;
                end
            end
            ST_MUL_V: begin
                state_next = ST_DIVS_V;
            end
            ST_DIVS_V: begin
                div_start  = 1'b1;
                state_next = ST_DIVW_V;
            end
            ST_DIVW_V: begin
                if (div_done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (out_of_image) begin
                    state_next = ST_RESULT;
                end else if (kp_total_reg == '0) begin
                    state_next = ST_DECIDE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (chain_ctl[NCELL].valid && chain_ctl[NCELL].last) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = is_match ? ST_FETCH : ST_RESULT;
            end
            ST_FETCH: begin
                used_we    = 1'b1;
                used_wd    = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                div_start  = 1'b1;
                state_next = ST_DIVW_R;
            end
            ST_DIVW_R: begin
                if (div_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
            m_valid_reg    <= 1'b0;
            match_cnt_reg  <= '0;
            iss_reg        <= 1'b0;
            pv_reg         <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_SWEEP) begin
                sweep_addr_reg <= (state_next == ST_SWEEP) ? sweep_addr_reg + 1'b1 : '0;
            end
            if (accept && (req_type_t'(s_tuser) == REQ_CLEAR)) begin
                match_cnt_reg <= '0;
            end else if (out_load && found_reg) begin
                match_cnt_reg <= cnt_inc;
            end
            // Multiply issue and product tracking for the camera point
            if (accept && (req_type_t'(s_tuser) == REQ_QUERY)) begin
                iss_reg <= 1'b1;
                pv_reg  <= 1'b0;
            end else begin
                pv_reg <= iss_reg;
                if (iss_reg && (ir_reg == 2'd2) && (ic_reg == 2'd2)) begin
                    iss_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath registers of the query
    always_ff @(posedge aclk) begin
        if (accept && (req_type_t'(s_tuser) == REQ_QUERY)) begin
            ir_reg    <= '0;
            ic_reg    <= '0;
            acc_reg   <= '0;
            found_reg <= 1'b0;
        end
        if (state_reg == ST_CAM) begin
            if (iss_reg) begin
                prod_reg <= pose_reg[{ir_reg, ic_reg}] * cam_in;
                pr_reg   <= ir_reg;
                pc_reg   <= ic_reg;
                if (ic_reg == 2'd2) begin
                    ic_reg <= '0;
                    ir_reg <= ir_reg + 2'd1;
                end else begin
                    ic_reg <= ic_reg + 2'd1;
                end
            end
            if (pv_reg) begin
                if (pc_reg == 2'd2) begin
                    cam_reg[pr_reg] <= sat32(acc_reg + term
                                             + 64'(pose_reg[{pr_reg, 2'd3}]));
                    acc_reg <= '0;
                end else begin
                    acc_reg <= acc_reg + term;
                end
            end
        end
        if (state_reg == ST_MUL_U) begin
            prod_reg <= $signed({1'b0, focal_x_reg}) * cam_reg[0];
        end
        if (state_reg == ST_MUL_V) begin
            prod_reg <= $signed({1'b0, focal_y_reg}) * cam_reg[1];
        end
        if ((state_reg == ST_DIVW_U) && div_done) begin
            u_reg <= q_signed + $signed({33'd0, center_x_reg});
        end
        if ((state_reg == ST_DIVW_V) && div_done) begin
            v_reg <= q_signed + $signed({33'd0, center_y_reg});
        end
        if (state_reg == ST_CHECK) begin
            scan_addr_reg <= '0;
        end else if (state_reg == ST_SCAN) begin
            scan_addr_reg <= scan_addr_reg + 1'b1;
        end
        if (state_reg == ST_DECIDE) begin
            found_reg <= is_match;
        end
        if ((state_reg == ST_DIVW_R) && div_done) begin
            u_right_reg <= sat32(64'($signed(pos_q[31:0])) - $signed(div_q));
        end
        if (out_load) begin
            out_found_reg  <= found_reg;
            out_slot_reg   <= found_reg ? IDX_W'(best_j_reg) : '0;
            out_uright_reg <= found_reg ? u_right_reg : 32'sd0;
            out_count_reg  <= found_reg ? cnt_inc : match_cnt_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {3'd0, out_count_reg, out_uright_reg, out_slot_reg};

endmodule
